@@ sv/range_velocity_accel_estimator_core_assert.svh @@
// assertion macros for the estimator core rtl
`ifndef RANGE_VELOCITY_ACCEL_ESTIMATOR_CORE_ASSERT_SVH
`define RANGE_VELOCITY_ACCEL_ESTIMATOR_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled in reset
`define RVAE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RVAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RVAE_ASSERT_IMPL(lbl, ante, cons, msg)
`define RVAE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/rvae_pkg.sv @@
package rvae_pkg;

  // field widths
  localparam int unsigned POS_W      = 20;
  localparam int unsigned SPEED_W    = 36;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // divisor and angle numerator widths
  localparam int unsigned DIVR_W = 16;
  localparam int unsigned NUM_W  = SCALE_W + ANGLE_W;

  // default fixed-point positions
  localparam int unsigned POS_FRAC_DEF  = 16;
  localparam int unsigned RATE_FRAC_DEF = 32;

  // register reset values
  localparam logic [PERIOD_W-1:0] RST_PERIOD    = 10'd20;
  localparam logic [POS_W-1:0]    RST_FAR_LIMIT = 20'd65536;
  localparam logic [POS_W-1:0]    RST_NOISE     = 20'd655;
  localparam logic [SCALE_W-1:0]  RST_SCALE     = 16'd1000;
  localparam logic [SCALE_W-1:0]  RST_SPEED_MIN = 16'd0;
  localparam logic [SCALE_W-1:0]  RST_SPEED_MAX = 16'd100;
  localparam logic [ANGLE_W-1:0]  RST_ANGLE_MIN = 8'd0;
  localparam logic [ANGLE_W-1:0]  RST_ANGLE_MAX = 8'd180;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 3'd0,
    CFG_FAR_LIMIT = 3'd1,
    CFG_NOISE     = 3'd2,
    CFG_SCALE     = 3'd3,
    CFG_SPEED_MIN = 3'd4,
    CFG_SPEED_MAX = 3'd5,
    CFG_ANGLE_MIN = 3'd6,
    CFG_ANGLE_MAX = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period;
    logic [POS_W-1:0]    far_limit;
    logic [POS_W-1:0]    noise_band;
    logic [SCALE_W-1:0]  speed_scale;
    logic [SCALE_W-1:0]  speed_min;
    logic [SCALE_W-1:0]  speed_max;
    logic [ANGLE_W-1:0]  angle_min;
    logic [ANGLE_W-1:0]  angle_max;
  } cfg_t;

  // channel payloads
  typedef struct packed {
    logic [POS_W-1:0] distance;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W-1:0] accel;
    logic [ANGLE_W-1:0] servo_angle;
    logic               angle_updated;
  } out_t;

  // divider operations
  typedef enum logic [1:0] {
    DIV_SPEED,
    DIV_ACCEL,
    DIV_ANGLE
  } div_op_e;

  typedef struct packed {
    logic    start;
    div_op_e op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

@@ sv/rvae_stream_if.sv @@
interface rvae_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ sv/range_velocity_accel_estimator_core.sv @@
// channel | dir | handshake       | payload
// in_i    | in  | valid / ready   | distance
// out_o   | out | valid / ready   | speed, accel, servo_angle, angle_updated
//
// a tracked sample is finished before the next one is accepted, its time set by the
// shared one-bit-per-cycle divider run for speed, accel, angle
// a forced-zero speed skips the speed division, a saturated angle skips the angle one
// the first sample after reset or a period write skips every division
// reset clears tracking state and loads register defaults; no clearing pass
// a waiting result only stalls the sequencer once the next result is ready to load

`include "range_velocity_accel_estimator_core_assert.svh"

module range_velocity_accel_estimator_core
  import rvae_pkg::*;
#(
  parameter int unsigned POS_FRAC_BITS  = POS_FRAC_DEF,
  parameter int unsigned RATE_FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rvae_stream_if.sink           in_i,
  rvae_stream_if.source         out_o
);

  localparam int unsigned DVW    = POS_W + RATE_FRAC_BITS;
  localparam int unsigned HALF_W = SPEED_W / 2;
  localparam int unsigned PROD_W = SPEED_W + SCALE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SPDW,
    S_ACC,
    S_ACCW,
    S_MUL0,
    S_MUL1,
    S_MAP,
    S_ANGW,
    S_FIN
  } state_e;

  state_e             state_q;
  logic               started_q;
  logic [POS_W-1:0]   dist_q;
  logic [POS_W-1:0]   last_pos_q;
  logic [SPEED_W-1:0] last_speed_q;
  logic [SPEED_W-1:0] spd_q;
  logic [SPEED_W-1:0] acc_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ANGLE_W-1:0] angle_q;
  logic               upd_q;
  logic               ang_neg_q;
  logic               out_valid_q;
  out_t               out_data_q;

  cfg_t               cfg;
  logic               cfg_clr;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [DVW-1:0]     div_dividend;
  logic [DIVR_W-1:0]  div_divisor;
  logic [DVW-1:0]     div_quot;

  // configuration registers
  rvae_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .clr_o      (cfg_clr)
  );

  // shared iterative divider
  rvae_div #(
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot)
  );

  // position difference and speed gating
  logic [POS_W-1:0]    pos_diff;
  logic                spd_forced;
  logic [PERIOD_W-1:0] period_eff;

  assign pos_diff   = (dist_q > last_pos_q) ? (dist_q - last_pos_q) : (last_pos_q - dist_q);
  assign spd_forced = (dist_q > cfg.far_limit) ||
                      ((pos_diff != '0) && (pos_diff < cfg.noise_band));
  assign period_eff = (cfg.sample_period == '0) ? PERIOD_W'(1) : cfg.sample_period;

  // speed quotient with fraction realignment and saturation
  logic [DVW-1:0]     spd_shift;
  logic               spd_sat;
  logic [SPEED_W-1:0] spd_new;

  assign spd_shift = div_quot >> POS_FRAC_BITS;
  assign spd_sat   = (spd_shift >> SPEED_W) != '0;
  assign spd_new   = spd_sat ? '1 : spd_shift[SPEED_W-1:0];

  // speed difference for acceleration
  logic [SPEED_W-1:0] spd_diff;

  assign spd_diff = (spd_q > last_speed_q) ? (spd_q - last_speed_q) : (last_speed_q - spd_q);

  // split speed times scale, one half per cycle
  logic [HALF_W-1:0]         mul_a;
  logic [HALF_W+SCALE_W-1:0] mul_p;

  assign mul_a = (state_q == S_MUL0) ? spd_q[HALF_W-1:0] : spd_q[SPEED_W-1:HALF_W];
  assign mul_p = mul_a * cfg.speed_scale;

  // servo mapping decisions and numerator
  logic [PROD_W-1:0]  scaled;
  logic               above_max;
  logic               below_min;
  logic               range_empty;
  logic               map_linear;
  logic [SCALE_W-1:0] spd_off;
  logic [ANGLE_W:0]   ang_diff;
  logic [ANGLE_W:0]   ang_diff_neg;
  logic [ANGLE_W-1:0] ang_mag;
  logic [NUM_W-1:0]   ang_num;

  assign scaled       = prod_q >> RATE_FRAC_BITS;
  assign above_max    = scaled > PROD_W'(cfg.speed_max);
  assign below_min    = scaled < PROD_W'(cfg.speed_min);
  assign range_empty  = cfg.speed_max <= cfg.speed_min;
  assign map_linear   = !above_max && !below_min && !range_empty;
  assign spd_off      = scaled[SCALE_W-1:0] - cfg.speed_min;
  assign ang_diff     = {1'b0, cfg.angle_max} - {1'b0, cfg.angle_min};
  assign ang_diff_neg = '0 - ang_diff;
  assign ang_mag      = ang_diff[ANGLE_W] ? ang_diff_neg[ANGLE_W-1:0] : ang_diff[ANGLE_W-1:0];
  assign ang_num      = spd_off * ang_mag;

  // signed quotient applied to the minimum angle, modulo 256
  logic [ANGLE_W-1:0] ang_q;
  logic [ANGLE_W-1:0] ang_q_neg;
  logic [ANGLE_W-1:0] ang_new;

  assign ang_q     = div_quot[ANGLE_W-1:0];
  assign ang_q_neg = '0 - ang_q;
  assign ang_new   = cfg.angle_min + (ang_neg_q ? ang_q_neg : ang_q);

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.op    = DIV_SPEED;
    div_dividend  = {pos_diff, {RATE_FRAC_BITS{1'b0}}};
    div_divisor   = DIVR_W'(period_eff);
    unique case (state_q)
      S_DIFF: begin
        div_req.start = started_q && !spd_forced;
      end
      S_ACC: begin
        div_req.start = 1'b1;
        div_req.op    = DIV_ACCEL;
        div_dividend  = DVW'(spd_diff);
      end
      S_MAP: begin
        div_req.start = map_linear;
        div_req.op    = DIV_ANGLE;
        div_dividend  = DVW'(ang_num);
        div_divisor   = cfg.speed_max - cfg.speed_min;
      end
      default: begin
      end
    endcase
  end

  logic out_free;

  assign out_free = !out_valid_q || out_o.ready;

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      started_q    <= 1'b0;
      dist_q       <= '0;
      last_pos_q   <= '0;
      last_speed_q <= '0;
      spd_q        <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      angle_q      <= '0;
      upd_q        <= 1'b0;
      ang_neg_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            dist_q  <= in_i.data.distance;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (!started_q) begin
            spd_q   <= '0;
            acc_q   <= '0;
            upd_q   <= 1'b0;
            state_q <= S_FIN;
          end else if (spd_forced) begin
            spd_q   <= '0;
            upd_q   <= 1'b1;
            state_q <= S_ACC;
          end else begin
            upd_q   <= 1'b1;
            state_q <= S_SPDW;
          end
        end
        S_SPDW: begin
          if (div_rsp.done) begin
            spd_q   <= spd_new;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          state_q <= S_ACCW;
        end
        S_ACCW: begin
          if (div_rsp.done) begin
            acc_q   <= div_quot[SPEED_W-1:0];
            state_q <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod_q  <= PROD_W'(mul_p);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= prod_q + (PROD_W'(mul_p) << HALF_W);
          state_q <= S_MAP;
        end
        S_MAP: begin
          ang_neg_q <= ang_diff[ANGLE_W];
          priority if (above_max) begin
            angle_q <= cfg.angle_max;
            state_q <= S_FIN;
          end else if (!map_linear) begin
            angle_q <= cfg.angle_min;
            state_q <= S_FIN;
          end else begin
            state_q <= S_ANGW;
          end
        end
        S_ANGW: begin
          if (div_rsp.done) begin
            angle_q <= ang_new;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q              <= 1'b1;
            out_data_q.speed         <= spd_q;
            out_data_q.accel         <= acc_q;
            out_data_q.servo_angle   <= angle_q;
            out_data_q.angle_updated <= upd_q;
            last_pos_q               <= dist_q;
            last_speed_q             <= spd_q;
            started_q                <= 1'b1;
            state_q                  <= S_IDLE;
          end
        end
      endcase
      // period write restarts tracking, angle kept
      if (cfg_clr) begin
        started_q    <= 1'b0;
        last_pos_q   <= '0;
        last_speed_q <= '0;
      end
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // checks on sequencing
  `RVAE_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "ready after accept")
  `RVAE_ASSERT_IMPL(a_div_done_waited, div_rsp.done, (state_q == S_SPDW) || (state_q == S_ACCW) || (state_q == S_ANGW), "divider result not awaited")
  `RVAE_ASSERT_IMPL(a_start_when_free, div_req.start, !div_rsp.busy && !div_rsp.done, "divider restarted while busy")
  `RVAE_ASSERT_NEXT(a_fin_loads_out, (state_q == S_FIN) && out_free, out_o.valid && in_i.ready, "result not loaded")
  `RVAE_ASSERT_IMPL(a_first_zero, out_o.valid && !out_o.data.angle_updated, (out_o.data.speed == '0) && (out_o.data.accel == '0), "first sample not zero")

endmodule

@@ sv/rvae_cfg.sv @@
module rvae_cfg
  import rvae_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output logic                  clr_o
);

  cfg_t cfg_q;

  // register file, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period <= RST_PERIOD;
      cfg_q.far_limit     <= RST_FAR_LIMIT;
      cfg_q.noise_band    <= RST_NOISE;
      cfg_q.speed_scale   <= RST_SCALE;
      cfg_q.speed_min     <= RST_SPEED_MIN;
      cfg_q.speed_max     <= RST_SPEED_MAX;
      cfg_q.angle_min     <= RST_ANGLE_MIN;
      cfg_q.angle_max     <= RST_ANGLE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD:    cfg_q.sample_period <= cfg_data_i[PERIOD_W-1:0];
        CFG_FAR_LIMIT: cfg_q.far_limit     <= cfg_data_i[POS_W-1:0];
        CFG_NOISE:     cfg_q.noise_band    <= cfg_data_i[POS_W-1:0];
        CFG_SCALE:     cfg_q.speed_scale   <= cfg_data_i[SCALE_W-1:0];
        CFG_SPEED_MIN: cfg_q.speed_min     <= cfg_data_i[SCALE_W-1:0];
        CFG_SPEED_MAX: cfg_q.speed_max     <= cfg_data_i[SCALE_W-1:0];
        CFG_ANGLE_MIN: cfg_q.angle_min     <= cfg_data_i[ANGLE_W-1:0];
        CFG_ANGLE_MAX: cfg_q.angle_max     <= cfg_data_i[ANGLE_W-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // a period write restarts tracking
  assign clr_o = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_PERIOD);

endmodule

@@ sv/rvae_div.sv @@
module rvae_div
  import rvae_pkg::*;
#(
  parameter int unsigned DVW = POS_W + RATE_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  input  logic [DVW-1:0]    dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output div_rsp_t          rsp_o,
  output logic [DVW-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(DVW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] div_q, div_d;
  logic [DVW-1:0]    dvd_q, dvd_d;

  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   trial_sub;
  logic              ge;

  // one restoring step: shift in next dividend bit, trial subtract
  assign trial     = {rem_q, dvd_q[DVW-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign ge        = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    if (req_i.start) begin
      // left-align the operand so only its own width is iterated
      busy_d = 1'b1;
      rem_d  = '0;
      div_d  = divisor_i;
      unique case (req_i.op)
        DIV_SPEED: begin
          dvd_d = dividend_i;
          cnt_d = CNT_W'(DVW);
        end
        DIV_ACCEL: begin
          dvd_d = dividend_i << (DVW - SPEED_W);
          cnt_d = CNT_W'(SPEED_W);
        end
        DIV_ANGLE: begin
          dvd_d = dividend_i << (DVW - NUM_W);
          cnt_d = CNT_W'(NUM_W);
        end
      endcase
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
      dvd_d = {dvd_q[DVW-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      dvd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
      dvd_q  <= dvd_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = dvd_q;

endmodule

@@ sim/tb_range_velocity_accel_estimator_core.sv @@
module tb_range_velocity_accel_estimator_core;
  import rvae_pkg::*;

  localparam int unsigned RAND_SAMPLES = 1100;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_GAP      = 14;
  localparam logic [63:0] SPEED_SAT    = (64'd1 << SPEED_W) - 64'd1;
  localparam int unsigned POS_TOP      = (1 << POS_W) - 1;

  // one row of the directed table: a register write or a distance sample
  typedef struct packed {
    logic                  is_reg;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    out_t                  want;
  } step_row_t;

  localparam out_t FIRST_ZERO = '{speed: '0, accel: '0, servo_angle: '0, angle_updated: 1'b0};
  localparam out_t STILL_ZERO = '{speed: '0, accel: '0, servo_angle: '0, angle_updated: 1'b1};
  localparam out_t NO_CHECK   = '0;

  localparam int unsigned NUM_DIR = 31;
  localparam step_row_t DIR_ROWS [NUM_DIR] = '{
    // first sample after reset, then no movement
    '{1'b0, CFG_PERIOD,    20'd0,      1'b1, FIRST_ZERO},
    '{1'b0, CFG_PERIOD,    20'd0,      1'b1, STILL_ZERO},
    // beyond the far limit, then right on it
    '{1'b0, CFG_PERIOD,    20'hFFFFF,  1'b1, STILL_ZERO},
    '{1'b0, CFG_PERIOD,    20'd65536,  1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd65536,  1'b0, NO_CHECK},
    // inside the noise band, one below its edge, then exactly on it
    '{1'b0, CFG_PERIOD,    20'd65000,  1'b1, STILL_ZERO},
    '{1'b0, CFG_PERIOD,    20'd64346,  1'b1, STILL_ZERO},
    '{1'b0, CFG_PERIOD,    20'd63691,  1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd0,      1'b0, NO_CHECK},
    // period of 1000; the write restarts tracking but keeps the angle
    '{1'b1, CFG_PERIOD,    20'd1000,   1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd1000,   1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd1001,   1'b0, NO_CHECK},
    // widest window, no noise band, shortest period: fastest speeds
    '{1'b1, CFG_FAR_LIMIT, 20'hFFFFF,  1'b0, NO_CHECK},
    '{1'b1, CFG_NOISE,     20'd0,      1'b0, NO_CHECK},
    '{1'b1, CFG_PERIOD,    20'd1,      1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd0,      1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'hFFFFF,  1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd0,      1'b0, NO_CHECK},
    // zero period counts as one; empty speed range hit exactly
    '{1'b1, CFG_PERIOD,    20'd0,      1'b0, NO_CHECK},
    '{1'b1, CFG_SCALE,     20'd65535,  1'b0, NO_CHECK},
    '{1'b1, CFG_SPEED_MIN, 20'd50,     1'b0, NO_CHECK},
    '{1'b1, CFG_SPEED_MAX, 20'd50,     1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd5,      1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd56,     1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd5000,   1'b0, NO_CHECK},
    // falling angle slope across the full speed range
    '{1'b1, CFG_ANGLE_MIN, 20'd180,    1'b0, NO_CHECK},
    '{1'b1, CFG_ANGLE_MAX, 20'd0,      1'b0, NO_CHECK},
    '{1'b1, CFG_SPEED_MIN, 20'd0,      1'b0, NO_CHECK},
    '{1'b1, CFG_SPEED_MAX, 20'd65535,  1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd30000,  1'b0, NO_CHECK},
    '{1'b0, CFG_PERIOD,    20'd1000,   1'b0, NO_CHECK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rvae_stream_if #(.payload_t(in_t))  dist_if ();
  rvae_stream_if #(.payload_t(out_t)) res_if ();

  range_velocity_accel_estimator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (dist_if),
    .out_o      (res_if)
  );

  // shadow of the register file and the tracking state
  cfg_t             cfg_shadow;
  logic             trk_started;
  logic [POS_W-1:0] trk_pos;
  logic [63:0]      trk_speed;
  logic [7:0]       servo_reg;

  // motion results still to come out, oldest first
  out_t pending_motion [$];

  bit          calm_phase;
  bit          hold_results;
  int unsigned err_cnt;
  int unsigned samples_sent;
  int unsigned results_seen;
  int unsigned reg_writes;

  // expected speed, acceleration and servo angle for one distance sample
  function automatic out_t track_sample(input logic [POS_W-1:0] range_in);
    out_t        res;
    logic [63:0] period;
    logic [63:0] diff;
    logic [63:0] quot;
    logic [63:0] spd;
    logic [63:0] acc;
    logic [63:0] scaled;
    longint      num;
    longint      den;
    res    = '0;
    spd    = '0;
    acc    = '0;
    period = (cfg_shadow.sample_period == '0) ? 64'd1 : 64'(cfg_shadow.sample_period);
    if (!trk_started) begin
      trk_started = 1'b1;
      trk_pos     = range_in;
      trk_speed   = '0;
    end else begin
      diff = (range_in > trk_pos) ? 64'(range_in - trk_pos) : 64'(trk_pos - range_in);
      if (range_in > cfg_shadow.far_limit ||
          (diff != 0 && diff < 64'(cfg_shadow.noise_band))) begin
        spd = '0;
      end else begin
        quot = ((diff << RATE_FRAC_DEF) / period) >> POS_FRAC_DEF;
        spd  = (quot > SPEED_SAT) ? SPEED_SAT : quot;
      end
      // linear servo mapping with clamps at both ends
      scaled = (spd * 64'(cfg_shadow.speed_scale)) >> RATE_FRAC_DEF;
      if (scaled > 64'(cfg_shadow.speed_max)) begin
        servo_reg = cfg_shadow.angle_max;
      end else if (scaled < 64'(cfg_shadow.speed_min)) begin
        servo_reg = cfg_shadow.angle_min;
      end else if (cfg_shadow.speed_max <= cfg_shadow.speed_min) begin
        servo_reg = cfg_shadow.angle_min;
      end else begin
        num = (longint'(scaled) - longint'(cfg_shadow.speed_min)) *
              (longint'(cfg_shadow.angle_max) - longint'(cfg_shadow.angle_min));
        den = longint'(cfg_shadow.speed_max) - longint'(cfg_shadow.speed_min);
        servo_reg = 8'(num / den + longint'(cfg_shadow.angle_min));
      end
      acc = ((spd > trk_speed) ? spd - trk_speed : trk_speed - spd) / period;
      trk_pos   = range_in;
      trk_speed = spd;
      res.angle_updated = 1'b1;
    end
    res.speed       = spd[SPEED_W-1:0];
    res.accel       = acc[SPEED_W-1:0];
    res.servo_angle = servo_reg;
    return res;
  endfunction

  // mostly random inside the range, now and then one of its ends
  function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7, 0))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // register write, mirrored once the edge has taken it
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_PERIOD: begin
        cfg_shadow.sample_period = val[PERIOD_W-1:0];
        trk_started = 1'b0;
        trk_pos     = '0;
        trk_speed   = '0;
      end
      CFG_FAR_LIMIT: cfg_shadow.far_limit   = val[POS_W-1:0];
      CFG_NOISE:     cfg_shadow.noise_band  = val[POS_W-1:0];
      CFG_SCALE:     cfg_shadow.speed_scale = val[SCALE_W-1:0];
      CFG_SPEED_MIN: cfg_shadow.speed_min   = val[SCALE_W-1:0];
      CFG_SPEED_MAX: cfg_shadow.speed_max   = val[SCALE_W-1:0];
      CFG_ANGLE_MIN: cfg_shadow.angle_min   = val[ANGLE_W-1:0];
      CFG_ANGLE_MAX: cfg_shadow.angle_max   = val[ANGLE_W-1:0];
      default: ;
    endcase
  endtask

  // offer one distance after a random gap and book its expected result
  task automatic send_sample(input logic [POS_W-1:0] range_in, input bit typed = 1'b0,
                             input out_t want = '0);
    int unsigned gap;
    out_t        predicted;
    gap = calm_phase ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      dist_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dist_if.valid <= 1'b1;
    dist_if.data  <= '{distance: range_in};
    do @(posedge clk_i); while (dist_if.ready !== 1'b1);
    predicted = track_sample(range_in);
    pending_motion.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // stop offering and let every booked result come out
  task automatic wait_idle();
    dist_if.valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb_range_velocity_accel_estimator_core: errors");
    $finish;
  end

  // result side: random back-pressure, one long hold, field-by-field compare
  initial begin
    int unsigned stall;
    out_t        want;
    out_t        got;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_results) begin
        stall        = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall = calm_phase ? 0 : $urandom_range(MAX_GAP, 0);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      got = res_if.data;
      results_seen++;
      if (pending_motion.size() == 0) begin
        $error("result transaction with nothing expected: speed %0d accel %0d angle %0d",
               got.speed, got.accel, got.servo_angle);
        err_cnt++;
      end else begin
        want = pending_motion.pop_front();
        if (got.speed !== want.speed) begin
          $error("speed: expected %0d, actual %0d", want.speed, got.speed);
          err_cnt++;
        end
        if (got.accel !== want.accel) begin
          $error("accel: expected %0d, actual %0d", want.accel, got.accel);
          err_cnt++;
        end
        if (got.servo_angle !== want.servo_angle) begin
          $error("servo_angle: expected %0d, actual %0d", want.servo_angle, got.servo_angle);
          err_cnt++;
        end
        if (got.angle_updated !== want.angle_updated) begin
          $error("angle_updated: expected %0d, actual %0d", want.angle_updated,
                 got.angle_updated);
          err_cnt++;
        end
      end
    end
  end

  // stimulus: directed table, then randomised phases
  initial begin
    bit          prev_reg;
    int unsigned rand_sent;
    int unsigned settings;
    int unsigned phase_len;
    int unsigned lo;
    int unsigned smin;
    int unsigned target;
    longint      period_eff;
    longint      step;
    longint      walk;
    bit          anywhere;
    bit          go_up;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PERIOD;
    cfg_data_i    = '0;
    dist_if.valid = 1'b0;
    dist_if.data  = '0;
    cfg_shadow    = '{sample_period: RST_PERIOD, far_limit: RST_FAR_LIMIT,
                      noise_band: RST_NOISE, speed_scale: RST_SCALE,
                      speed_min: RST_SPEED_MIN, speed_max: RST_SPEED_MAX,
                      angle_min: RST_ANGLE_MIN, angle_max: RST_ANGLE_MAX};
    trk_started   = 1'b0;
    trk_pos       = '0;
    trk_speed     = '0;
    servo_reg     = '0;
    calm_phase    = 1'b0;
    hold_results  = 1'b0;
    prev_reg      = 1'b0;
    rand_sent     = 0;
    settings      = 1;
    walk          = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int r = 0; r < NUM_DIR; r++) begin
      if (DIR_ROWS[r].is_reg) begin
        if (!prev_reg) begin
          wait_idle();
          settings++;
        end
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].value);
      end else begin
        if (prev_reg) cfg_we_i <= 1'b0;
        send_sample(DIR_ROWS[r].value[POS_W-1:0], DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
      prev_reg = DIR_ROWS[r].is_reg;
    end

    // random phases, each under a fresh register setting
    while (rand_sent < RAND_SAMPLES) begin
      wait_idle();
      settings++;
      if ($urandom_range(2, 0) == 0)
        write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(1, 0) ? pick_in(1, 1000)
                                                              : $urandom_range(40, 1)));
      if ($urandom_range(1, 0))
        write_reg(CFG_FAR_LIMIT, CFG_DATA_W'($urandom_range(1, 0) ? POS_TOP
                                                                 : pick_in(0, POS_TOP)));
      if ($urandom_range(1, 0))
        write_reg(CFG_NOISE, CFG_DATA_W'($urandom_range(3, 0) == 0 ? pick_in(0, POS_TOP)
                                                                  : $urandom_range(3000, 0)));
      if ($urandom_range(1, 0))
        write_reg(CFG_SCALE, CFG_DATA_W'(pick_in(1, 65535)));
      if ($urandom_range(1, 0)) begin
        // speed window kept well formed, often narrow and low
        if ($urandom_range(1, 0)) begin
          smin = $urandom_range(200, 0);
          write_reg(CFG_SPEED_MIN, CFG_DATA_W'(smin));
          write_reg(CFG_SPEED_MAX, CFG_DATA_W'(smin + $urandom_range(400, 1)));
        end else begin
          smin = pick_in(0, 65534);
          write_reg(CFG_SPEED_MIN, CFG_DATA_W'(smin));
          write_reg(CFG_SPEED_MAX, CFG_DATA_W'(pick_in(smin + 1, 65535)));
        end
      end
      if ($urandom_range(1, 0))
        write_reg(CFG_ANGLE_MIN, CFG_DATA_W'(pick_in(0, 180)));
      if ($urandom_range(1, 0))
        write_reg(CFG_ANGLE_MAX, CFG_DATA_W'(pick_in(0, 180)));
      cfg_we_i <= 1'b0;

      phase_len  = $urandom_range(80, 20);
      calm_phase = ($urandom_range(3, 0) == 0);
      // one phase with the result side held off while samples keep coming
      if (settings == 8) begin
        calm_phase   = 1'b1;
        hold_results = 1'b1;
      end

      for (int k = 0; k < phase_len && rand_sent < RAND_SAMPLES; k++) begin
        period_eff = (cfg_shadow.sample_period == '0) ? 1 : longint'(cfg_shadow.sample_period);
        anywhere   = 1'b0;
        step       = 0;
        case ($urandom_range(9, 0))
          0, 1, 2, 3, 4: begin
            // aim the position change at a speed around the mapped window
            lo     = (cfg_shadow.speed_min > 2) ? cfg_shadow.speed_min - 2 : 0;
            target = $urandom_range(int'(cfg_shadow.speed_max) + 2, lo);
            step   = ((longint'(target) * period_eff) << POS_FRAC_DEF) /
                     longint'(cfg_shadow.speed_scale);
          end
          5, 6:    step = $urandom_range(2 * int'(cfg_shadow.noise_band) + 1, 0);
          7:       step = $urandom_range(4000, 0);
          8:       step = 0;
          default: anywhere = 1'b1;
        endcase
        if (anywhere) begin
          walk = $urandom_range(POS_TOP, 0);
        end else begin
          if (step > POS_TOP) step = POS_TOP;
          go_up = $urandom_range(1, 0);
          if (go_up && walk + step > POS_TOP) go_up = 1'b0;
          if (!go_up && walk < step) go_up = 1'b1;
          walk = go_up ? walk + step : walk - step;
          if (walk > POS_TOP) walk = POS_TOP;
        end
        send_sample(POS_W'(walk));
        rand_sent++;
      end
    end

    // drain
    calm_phase = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d distance samples and %0d checked results", samples_sent,
             results_seen);
    $display("over %0d register writes in %0d settings, including one long output stall",
             reg_writes, settings);
    if (err_cnt == 0) begin
      $display("tb_range_velocity_accel_estimator_core: clean");
    end else begin
      $display("tb_range_velocity_accel_estimator_core: errors");
    end
    $finish;
  end

endmodule
